FILE: design/iee_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iee_pkg
// Shared types, codes and character decode for the infix expression evaluator.
// ---------------------------------------------------------------------------
package iee_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    CL_START = 3'd0,
    CL_DIGIT = 3'd1,
    CL_ADD   = 3'd2,
    CL_MUL   = 3'd3,
    CL_OTHER = 3'd4,
    CL_SPACE = 3'd5
  } cls_t;

  typedef enum logic [1:0] {
    OP_PLUS  = 2'd0,
    OP_MINUS = 2'd1,
    OP_MUL   = 2'd2,
    OP_DIV   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_UNEXP = 3'd2,
    ST_PLACE = 3'd3,
    ST_UNARY = 3'd4,
    ST_DIVZ  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_APPLY = 2'd1,
    S_WAIT  = 2'd2,
    S_DONE  = 2'd3
  } ctl_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] value;
  } out_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } arith_req_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    if (c >= CH_ZERO && c <= CH_NINE) r = CL_DIGIT;
    else if (c == CH_PLUS || c == CH_MINUS) r = CL_ADD;
    else if (c == CH_STAR || c == CH_SLASH) r = CL_MUL;
    else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) r = CL_SPACE;
    else r = CL_OTHER;
    return r;
  endfunction

endpackage

FILE: design/iee_arith.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iee_arith
// Bit-serial wrapping multiply and signed truncating divide, one bit per cycle.
// ---------------------------------------------------------------------------
module iee_arith #(
  parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  iee_pkg::arith_req_t    req,
  input  logic [VALUE_WIDTH-1:0] opnd_a,
  input  logic [VALUE_WIDTH-1:0] opnd_b,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic          is_div_r;
  logic          neg_r;
  logic [W:0]    acc_r;   // product, or partial remainder
  logic [W-1:0]  opa_r;   // multiplicand, or dividend/quotient shift
  logic [W-1:0]  opb_r;   // multiplier, or divisor magnitude

  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [W-1:0] psum;

  always_comb begin
    mag_a  = opnd_a[W-1] ? -opnd_a : opnd_a;
    mag_b  = opnd_b[W-1] ? -opnd_b : opnd_b;
    rem_sh = {acc_r[W-1:0], opa_r[W-1]};
    diff   = rem_sh - {1'b0, opb_r};
    psum   = acc_r[W-1:0] + (opb_r[0] ? opa_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        is_div_r <= req.is_div;
        neg_r    <= opnd_a[W-1] ^ opnd_b[W-1];
        acc_r    <= '0;
        opa_r    <= req.is_div ? mag_a : opnd_a;
        opb_r    <= req.is_div ? mag_b : opnd_b;
      end else if (busy_r) begin
        if (is_div_r) begin
          // restoring step: subtract when it does not go negative
          if (!diff[W]) begin
            acc_r <= diff;
            opa_r <= {opa_r[W-2:0], 1'b1};
          end else begin
            acc_r <= rem_sh;
            opa_r <= {opa_r[W-2:0], 1'b0};
          end
        end else begin
          acc_r <= {1'b0, psum};
          opa_r <= {opa_r[W-2:0], 1'b0};
          opb_r <= {1'b0, opb_r[W-1:1]};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = is_div_r ? (neg_r ? -opa_r : opa_r) : acc_r[W-1:0];

endmodule

FILE: design/infix_expression_evaluator_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// infix_expression_evaluator_core
// Streaming checker and evaluator for parenthesis-free integer expressions.
// ---------------------------------------------------------------------------
// One character is taken per transfer; the transfer flagged last yields one
// result with status and value. A digit, whitespace or other character is
// taken in the idle state. A transfer that runs the pending operation (+ or -
// after a digit or other character, any * or /, or a last transfer on or
// after a digit) goes to the apply state. For + or -, or a divide by zero,
// apply returns to idle or goes to done; any other * or / starts the
// bit-serial multiply/divide unit, which retires one bit per cycle, and waits
// in the wait state until it finishes. A last transfer ends in the done
// state, which loads the result register once out_stall no longer holds an
// earlier result there. Input is taken while a loaded result waits.
module infix_expression_evaluator_core #(
  parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  iee_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output iee_pkg::out_t out_data
);

  localparam int W = VALUE_WIDTH;

  iee_pkg::ctl_state_t state_r, state_nxt;

  logic [W-1:0]      sum_r;
  logic [W-1:0]      top_r;
  logic [W-1:0]      num_r;
  iee_pkg::op_t      pend_r;
  logic              unary_r;
  iee_pkg::cls_t     prev_r;
  iee_pkg::cls_t     prev2_r;
  iee_pkg::status_t  ferr_r;
  logic              divz_r;
  iee_pkg::op_t      new_op_r;
  logic              set_op_r;
  logic              last_r;
  logic              out_valid_r;
  iee_pkg::out_t     out_data_r;

  // accept-side decode
  logic              take;
  iee_pkg::cls_t     cls_c;
  iee_pkg::cls_t     prev_new_c;
  iee_pkg::status_t  err_c;
  iee_pkg::status_t  ferr_new_c;
  logic              prev_unary_c;
  logic              do_apply_c;
  logic              fin_apply_c;
  iee_pkg::op_t      new_op_c;
  logic [3:0]        digit_c;
  logic [W-1:0]      num_new_c;

  // apply / finish
  logic [W-1:0]      opnd_c;
  logic              quick_c;
  logic              out_load;
  iee_pkg::arith_req_t arith_req;
  logic              arith_done;
  logic [W-1:0]      arith_res;
  logic [W-1:0]      total_c;
  logic signed [W-1:0] total_s;
  iee_pkg::status_t  status_c;

  iee_arith #(.VALUE_WIDTH(W)) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (arith_req),
    .opnd_a (top_r),
    .opnd_b (opnd_c),
    .done   (arith_done),
    .result (arith_res)
  );

  always_comb begin
    cls_c        = iee_pkg::classify(in_data.ch);
    prev_unary_c = prev_r == iee_pkg::CL_ADD &&
                   (prev2_r == iee_pkg::CL_START || prev2_r == iee_pkg::CL_ADD ||
                    prev2_r == iee_pkg::CL_MUL);
    priority if (prev_r == iee_pkg::CL_MUL &&
                 (cls_c == iee_pkg::CL_ADD || cls_c == iee_pkg::CL_MUL))
      err_c = iee_pkg::ST_PLACE;
    else if (prev_unary_c && cls_c == iee_pkg::CL_ADD)
      err_c = iee_pkg::ST_UNARY;
    else if (cls_c == iee_pkg::CL_OTHER)
      err_c = iee_pkg::ST_UNEXP;
    else if (cls_c == iee_pkg::CL_MUL && prev_r == iee_pkg::CL_START)
      err_c = iee_pkg::ST_PLACE;
    else
      err_c = iee_pkg::ST_OK;

    prev_new_c = (cls_c == iee_pkg::CL_SPACE) ? prev_r : cls_c;
    ferr_new_c = ferr_r;
    if (cls_c != iee_pkg::CL_SPACE && ferr_r == iee_pkg::ST_OK)
      ferr_new_c = err_c;
    // an expression may not end on * or /
    if (in_data.last && prev_new_c == iee_pkg::CL_MUL && ferr_new_c == iee_pkg::ST_OK)
      ferr_new_c = iee_pkg::ST_PLACE;

    do_apply_c  = (cls_c == iee_pkg::CL_ADD &&
                   (prev_r == iee_pkg::CL_DIGIT || prev_r == iee_pkg::CL_OTHER)) ||
                  cls_c == iee_pkg::CL_MUL;
    fin_apply_c = in_data.last && prev_new_c == iee_pkg::CL_DIGIT;

    unique case (in_data.ch)
      iee_pkg::CH_MINUS: new_op_c = iee_pkg::OP_MINUS;
      iee_pkg::CH_STAR:  new_op_c = iee_pkg::OP_MUL;
      iee_pkg::CH_SLASH: new_op_c = iee_pkg::OP_DIV;
      default:           new_op_c = iee_pkg::OP_PLUS;
    endcase

    digit_c   = 4'(in_data.ch - iee_pkg::CH_ZERO);
    // times ten as two shifted copies
    num_new_c = (num_r << 3) + (num_r << 1) + W'(digit_c);

    opnd_c  = unary_r ? -num_r : num_r;
    quick_c = pend_r == iee_pkg::OP_PLUS || pend_r == iee_pkg::OP_MINUS ||
              (pend_r == iee_pkg::OP_DIV && opnd_c == '0);

    total_c = sum_r + top_r;
    total_s = total_c;
    if (prev_r == iee_pkg::CL_START)
      status_c = iee_pkg::ST_EMPTY;
    else if (ferr_r != iee_pkg::ST_OK)
      status_c = ferr_r;
    else if (divz_r)
      status_c = iee_pkg::ST_DIVZ;
    else
      status_c = iee_pkg::ST_OK;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iee_pkg::S_IDLE: begin
        if (in_valid) begin
          if (do_apply_c || fin_apply_c) state_nxt = iee_pkg::S_APPLY;
          else if (in_data.last)         state_nxt = iee_pkg::S_DONE;
        end
      end
      iee_pkg::S_APPLY: begin
        if (!quick_c)    state_nxt = iee_pkg::S_WAIT;
        else if (last_r) state_nxt = iee_pkg::S_DONE;
        else             state_nxt = iee_pkg::S_IDLE;
      end
      iee_pkg::S_WAIT: begin
        if (arith_done) state_nxt = last_r ? iee_pkg::S_DONE : iee_pkg::S_IDLE;
      end
      iee_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = iee_pkg::S_IDLE;
      end
      default: state_nxt = iee_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall         = state_r != iee_pkg::S_IDLE;
    take             = state_r == iee_pkg::S_IDLE && in_valid;
    arith_req.start  = state_r == iee_pkg::S_APPLY && !quick_c;
    arith_req.is_div = pend_r == iee_pkg::OP_DIV;
    out_load         = state_r == iee_pkg::S_DONE && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iee_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      top_r       <= '0;
      num_r       <= '0;
      pend_r      <= iee_pkg::OP_PLUS;
      unary_r     <= 1'b0;
      prev_r      <= iee_pkg::CL_START;
      prev2_r     <= iee_pkg::CL_START;
      ferr_r      <= iee_pkg::ST_OK;
      divz_r      <= 1'b0;
      set_op_r    <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      if (take) begin
        ferr_r   <= ferr_new_c;
        new_op_r <= new_op_c;
        set_op_r <= do_apply_c;
        last_r   <= in_data.last;
        if (cls_c != iee_pkg::CL_SPACE) begin
          prev_r  <= cls_c;
          prev2_r <= prev_r;
        end
        if (cls_c == iee_pkg::CL_DIGIT)
          num_r <= num_new_c;
        if (cls_c == iee_pkg::CL_ADD && !do_apply_c && in_data.ch == iee_pkg::CH_MINUS)
          unary_r <= ~unary_r;
      end

      if (state_r == iee_pkg::S_APPLY) begin
        unique case (pend_r)
          iee_pkg::OP_PLUS, iee_pkg::OP_MINUS: begin
            sum_r <= sum_r + top_r;
            top_r <= ((pend_r == iee_pkg::OP_MINUS) ^ unary_r) ? -num_r : num_r;
          end
          iee_pkg::OP_DIV: begin
            if (opnd_c == '0) divz_r <= 1'b1;
          end
          iee_pkg::OP_MUL: ;
          default: ;
        endcase
        num_r   <= '0;
        unary_r <= 1'b0;
        if (set_op_r) pend_r <= new_op_r;
      end

      if (state_r == iee_pkg::S_WAIT && arith_done)
        top_r <= arith_res;

      if (out_load) begin
        sum_r   <= '0;
        top_r   <= '0;
        num_r   <= '0;
        pend_r  <= iee_pkg::OP_PLUS;
        unary_r <= 1'b0;
        prev_r  <= iee_pkg::CL_START;
        prev2_r <= iee_pkg::CL_START;
        ferr_r  <= iee_pkg::ST_OK;
        divz_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.status <= status_c;
      out_data_r.value  <= (status_c == iee_pkg::ST_OK) ? 32'(total_s) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    arith_done |-> state_r == iee_pkg::S_WAIT)
    else $error("multiply/divide finished outside the wait state");

  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != iee_pkg::ST_OK) |-> out_data.value == '0)
    else $error("nonzero value reported with an error status");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (prev_r == iee_pkg::CL_START && ferr_r == iee_pkg::ST_OK && !divz_r))
    else $error("expression state not cleared after result");

  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iee_pkg::S_DONE && out_valid_r && out_stall) |=>
      state_r == iee_pkg::S_DONE)
    else $error("result dropped while output register was full");

  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> last_r)
    else $error("result produced without a last transfer");

endmodule
